[sv/ecc_pkg.sv]
`default_nettype none

package ecc_pkg;

	localparam int MAX_FLOORS = 16;
	localparam int FLOOR_W    = 4;
	localparam int MASK_W     = 16;
	localparam int DWELL_W    = 8;
	localparam int IN_W       = 16;
	localparam int OUT_W      = 32;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 8;

	localparam logic [FLOOR_W-1:0] LAST_FLOOR = FLOOR_W'(MAX_FLOORS - 1);

	localparam logic [CFG_IDX_W-1:0] REG_DWELL_TICKS = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOP_FLOOR   = 1'd1;

	typedef enum logic [1:0] {
		ST_IDLE    = 2'd0,
		ST_MOVING  = 2'd1,
		ST_STOPPED = 2'd2
	} ctrl_state_t;

	typedef enum logic [1:0] {
		DIR_IDLE = 2'd0,
		DIR_UP   = 2'd1,
		DIR_DOWN = 2'd2
	} dir_t;

	typedef enum logic [1:0] {
		SQ_WAIT = 2'd0,
		SQ_TICK = 2'd1,
		SQ_SCAN = 2'd2,
		SQ_OUT  = 2'd3
	} seq_state_t;

	typedef struct packed {
		logic done;
		logic above;
		logic below;
	} scan_res_t;

endpackage

`default_nettype wire

[sv/elevator_collective_controller_top.sv]
`default_nettype none

// Collective elevator controller. Each s_tdata transfer may record a hall
// call and a car call, and with advance set runs one controller tick; every
// input transfer yields exactly one m_tdata transfer with the car state.
// Items are handled one at a time and s_tready is low while one is in work.
// An item without a tick goes from its input transfer straight to output.
// A tick while moving, a dwell countdown or an idle stop at the car's own
// floor finishes without a scan. A tick that must look for requests above and below the
// car (idle, or leaving a stop) runs a floor scan through one shared compare
// unit, one floor per cycle from floor 0 to the highest served floor.
// While m_tready holds back a waiting result, the item stalls in output and
// s_tready stays low. Registers: index 0 dwell_ticks,
// index 1 top_floor (low four bits of cfg_data); write them only while idle.

module elevator_collective_controller_top
	import ecc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	// summon_valid, summon_floor, dest_valid, dest_floor, advance, zero fill
	input  wire logic [IN_W-1:0]       s_tdata,
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	// car_floor, motor_dir, ctrl_state, pending_mask, request_ignored, zero fill
	output logic [OUT_W-1:0]           m_tdata,
	input  wire logic                  cfg_valid,
	output logic                       cfg_ready,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	logic [DWELL_W-1:0] dwell_ticks_q;
	logic [FLOOR_W-1:0] top_floor_q;

	logic [MASK_W-1:0]  req_q;
	ctrl_state_t        fsm_q;
	logic [DWELL_W-1:0] dwell_q;
	dir_t               last_dir_q;
	dir_t               drive_q;
	logic [FLOOR_W-1:0] floor_q;
	logic               ignored_q;

	seq_state_t         seq_q;
	seq_state_t         seq_d;

	logic               m_tvalid_q;
	logic [OUT_W-1:0]   m_tdata_q;

	logic [FLOOR_W-1:0] lim;
	logic               in_xfer;
	logic               out_free;
	logic               scan_start;
	logic               tick_done;
	scan_res_t          scan_res;

	logic               sv_in;
	logic [FLOOR_W-1:0] sf_in;
	logic               dv_in;
	logic [FLOOR_W-1:0] df_in;
	logic               adv_in;

	logic               up_ok;
	logic               dn_ok;
	logic               stepped;
	logic [FLOOR_W-1:0] step_floor;
	logic               here_step;
	logic               here_now;

	logic               go_up;
	logic               go_dn;

	assign sv_in  = s_tdata[0];
	assign sf_in  = s_tdata[4:1];
	assign dv_in  = s_tdata[5];
	assign df_in  = s_tdata[9:6];
	assign adv_in = s_tdata[10];

	assign lim       = (top_floor_q > LAST_FLOOR) ? LAST_FLOOR : top_floor_q;
	assign in_xfer   = s_tvalid && s_tready;
	assign out_free  = !m_tvalid_q || m_tready;
	assign cfg_ready = 1'b1;

	// motor step and request check at the floor reached
	assign up_ok      = (drive_q == DIR_UP) && (floor_q < lim);
	assign dn_ok      = (drive_q == DIR_DOWN) && (floor_q != '0);
	assign stepped    = up_ok || dn_ok;
	assign step_floor = up_ok ? (floor_q + 1'b1) : (dn_ok ? (floor_q - 1'b1) : floor_q);
	assign here_step  = req_q[step_floor] && (step_floor <= lim);
	assign here_now   = req_q[floor_q] && (floor_q <= lim);

	// direction choice after the scan
	always_comb begin
		go_up = 1'b0;
		go_dn = 1'b0;
		if ((fsm_q == ST_STOPPED) && (last_dir_q == DIR_DOWN)) begin
			go_dn = scan_res.below;
			go_up = !scan_res.below && scan_res.above;
		end else begin
			go_up = scan_res.above;
			go_dn = !scan_res.above && scan_res.below;
		end
	end

	// whether the tick finishes without a scan
	always_comb begin
		case (fsm_q)
			ST_MOVING:  tick_done = 1'b1;
			ST_STOPPED: tick_done = (dwell_q != '0);
			default:    tick_done = here_now;
		endcase
	end

	always_comb begin
		seq_d = seq_q;
		case (seq_q)
			SQ_WAIT: begin
				if (in_xfer) begin
					seq_d = adv_in ? SQ_TICK : SQ_OUT;
				end
			end
			SQ_TICK: begin
				seq_d = tick_done ? SQ_OUT : SQ_SCAN;
			end
			SQ_SCAN: begin
				if (scan_res.done) begin
					seq_d = SQ_OUT;
				end
			end
			SQ_OUT: begin
				if (out_free) begin
					seq_d = SQ_WAIT;
				end
			end
			default: seq_d = SQ_WAIT;
		endcase
	end

	always_comb begin
		s_tready   = (seq_q == SQ_WAIT);
		scan_start = (seq_q == SQ_TICK) && !tick_done;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q <= SQ_WAIT;
		end else begin
			seq_q <= seq_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dwell_ticks_q <= DWELL_W'(5);
			top_floor_q   <= FLOOR_W'(9);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_DWELL_TICKS: dwell_ticks_q <= cfg_data;
				REG_TOP_FLOOR:   top_floor_q   <= cfg_data[FLOOR_W-1:0];
				default:         ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_q      <= '0;
			fsm_q      <= ST_IDLE;
			dwell_q    <= '0;
			last_dir_q <= DIR_IDLE;
			drive_q    <= DIR_IDLE;
			floor_q    <= '0;
			ignored_q  <= 1'b0;
		end else begin
			case (seq_q)
				SQ_WAIT: begin
					if (in_xfer) begin
						ignored_q <= (sv_in && (sf_in > lim)) || (dv_in && (df_in > lim));
						req_q     <= req_q
							| ((sv_in && (sf_in <= lim)) ? (MASK_W'(1) << sf_in) : '0)
							| ((dv_in && (df_in <= lim)) ? (MASK_W'(1) << df_in) : '0);
					end
				end
				SQ_TICK: begin
					case (fsm_q)
						ST_MOVING: begin
							floor_q <= step_floor;
							if (!stepped || here_step) begin
								drive_q <= DIR_IDLE;
								fsm_q   <= ST_STOPPED;
								dwell_q <= dwell_ticks_q;
							end
						end
						ST_STOPPED: begin
							if (dwell_q != '0) begin
								dwell_q <= dwell_q - 1'b1;
							end else begin
								req_q[floor_q] <= 1'b0;
							end
						end
						default: begin
							if (here_now) begin
								drive_q <= DIR_IDLE;
								fsm_q   <= ST_STOPPED;
								dwell_q <= dwell_ticks_q;
							end
						end
					endcase
				end
				SQ_SCAN: begin
					if (scan_res.done) begin
						if (go_up) begin
							drive_q    <= DIR_UP;
							last_dir_q <= DIR_UP;
							fsm_q      <= ST_MOVING;
						end else if (go_dn) begin
							drive_q    <= DIR_DOWN;
							last_dir_q <= DIR_DOWN;
							fsm_q      <= ST_MOVING;
						end else begin
							drive_q <= DIR_IDLE;
							fsm_q   <= ST_IDLE;
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if ((seq_q == SQ_OUT) && out_free) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((seq_q == SQ_OUT) && out_free) begin
			m_tdata_q <= {7'd0, ignored_q, req_q, fsm_q, drive_q, floor_q};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	ecc_scan u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (scan_start),
		.mask      (req_q),
		.floor_num (floor_q),
		.lim       (lim),
		.res       (scan_res)
	);

endmodule

`default_nettype wire

[sv/ecc_scan.sv]
`default_nettype none

module ecc_scan
	import ecc_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               start,
	input  wire logic [MASK_W-1:0]  mask,
	input  wire logic [FLOOR_W-1:0] floor_num,
	input  wire logic [FLOOR_W-1:0] lim,
	output scan_res_t               res
);

	logic [FLOOR_W-1:0] idx_q;
	logic               run_q;
	logic               done_q;
	logic               above_q;
	logic               below_q;
	logic               hit;

	assign hit = mask[idx_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			run_q   <= 1'b0;
			done_q  <= 1'b0;
			above_q <= 1'b0;
			below_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				idx_q   <= '0;
				run_q   <= 1'b1;
				above_q <= 1'b0;
				below_q <= 1'b0;
			end else if (run_q) begin
				// one floor per cycle through the shared compare
				if (hit && (idx_q > floor_num)) begin
					above_q <= 1'b1;
				end
				if (hit && (idx_q < floor_num)) begin
					below_q <= 1'b1;
				end
				if (idx_q == lim) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end else begin
					idx_q <= idx_q + 1'b1;
				end
			end
		end
	end

	assign res.done  = done_q;
	assign res.above = above_q;
	assign res.below = below_q;

endmodule

`default_nettype wire
